// ===== rtl/flfsr_pkg.sv =====
// Shared constants, register indexes and controller/datapath types of the frame sync receiver.
package flfsr_pkg;

    localparam int BYTE_W     = 8;
    localparam int POS_W      = 4;
    localparam int FLEN_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int MIN_LEN    = 3;
    localparam int LEN_CAP    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHECKSUM_ENABLE = 2'd2;

    typedef struct packed {
        logic wr_en;
        logic shift;
        logic sum_clr;
        logic sum_add;
        logic snap;
        logic out_load;
        logic out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic rx_is_start;
        logic rd_is_start;
        logic sum_ok;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/flfsr_cfg.sv =====
// Configuration registers and effective frame length saturation.
module flfsr_cfg #(
    parameter int STORE_DEPTH = 16,
    localparam int LEN_W = $clog2(STORE_DEPTH + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [flfsr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [flfsr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output logic [flfsr_pkg::BYTE_W-1:0]        start_byte,
    output logic                                checksum_enable,
    output logic [LEN_W-1:0]                    eff_len
);

    logic [flfsr_pkg::BYTE_W-1:0] start_byte_reg;
    logic [flfsr_pkg::FLEN_W-1:0] frame_length_reg;
    logic                         checksum_enable_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg      <= '0;
            frame_length_reg    <= flfsr_pkg::FLEN_W'(12);
            checksum_enable_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                flfsr_pkg::REG_START_BYTE: begin
                    start_byte_reg <= cfg_wdata[flfsr_pkg::BYTE_W-1:0];
                end
                flfsr_pkg::REG_FRAME_LENGTH: begin
                    frame_length_reg <= cfg_wdata[flfsr_pkg::FLEN_W-1:0];
                end
                flfsr_pkg::REG_CHECKSUM_ENABLE: begin
                    checksum_enable_reg <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (frame_length_reg < flfsr_pkg::FLEN_W'(flfsr_pkg::MIN_LEN)) begin
            eff_len = LEN_W'(flfsr_pkg::MIN_LEN);
        end else if (frame_length_reg > flfsr_pkg::FLEN_W'(STORE_DEPTH)) begin
            eff_len = LEN_W'(STORE_DEPTH);
        end else begin
            eff_len = LEN_W'(frame_length_reg);
        end
    end

    assign start_byte      = start_byte_reg;
    assign checksum_enable = checksum_enable_reg;

endmodule

// ===== rtl/flfsr_dp.sv =====
// Datapath: frame store, checksum accumulator, compare logic and output register.
module flfsr_dp #(
    parameter int STORE_DEPTH = 16,
    localparam int IDX_W = $clog2(STORE_DEPTH)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  flfsr_pkg::dp_cmd_t               cmd,
    input  logic [IDX_W-1:0]                 wr_idx,
    input  logic [IDX_W-1:0]                 rd_idx,
    input  logic [IDX_W-1:0]                 out_pos,
    input  logic [flfsr_pkg::BYTE_W-1:0]     rx_byte,
    input  logic [flfsr_pkg::BYTE_W-1:0]     start_byte,
    input  logic                             checksum_enable,
    output flfsr_pkg::dp_status_t            status,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [flfsr_pkg::BYTE_W-1:0]     m_frame_byte,
    output logic [flfsr_pkg::POS_W-1:0]      m_byte_position,
    output logic                             m_last
);

    logic [flfsr_pkg::BYTE_W-1:0] store_reg [STORE_DEPTH];
    logic [flfsr_pkg::BYTE_W-1:0] store_next [STORE_DEPTH];
    logic [flfsr_pkg::BYTE_W-1:0] sum_reg;
    logic [flfsr_pkg::BYTE_W-1:0] sum_next;
    logic [flfsr_pkg::BYTE_W-1:0] start_snap_reg;
    logic                         csum_snap_reg;
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [flfsr_pkg::BYTE_W-1:0] m_frame_byte_reg;
    logic [flfsr_pkg::POS_W-1:0]  m_byte_position_reg;
    logic                         m_last_reg;
    logic [flfsr_pkg::BYTE_W-1:0] rd_byte;

    assign rd_byte = store_reg[rd_idx];

    always_comb begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            store_next[i] = store_reg[i];
        end
        if (cmd.shift) begin
            for (int i = 0; i < STORE_DEPTH - 1; i++) begin
                store_next[i] = store_reg[i + 1];
            end
        end else if (cmd.wr_en) begin
            store_next[wr_idx] = rx_byte;
        end
    end

    always_comb begin
        sum_next = sum_reg;
        if (cmd.sum_clr) begin
            sum_next = '0;
        end else if (cmd.sum_add) begin
            sum_next = sum_reg + rd_byte;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            store_reg[i] <= store_next[i];
        end
        sum_reg <= sum_next;
        if (cmd.snap) begin
            start_snap_reg <= start_byte;
            csum_snap_reg  <= checksum_enable;
        end
        if (cmd.out_load) begin
            m_frame_byte_reg    <= rd_byte;
            m_byte_position_reg <= flfsr_pkg::POS_W'(out_pos);
            m_last_reg          <= cmd.out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign status.rx_is_start = (rx_byte == start_byte);
    assign status.rd_is_start = (rd_byte == start_snap_reg);
    assign status.sum_ok      = !csum_snap_reg || (rd_byte == sum_reg);
    assign status.out_free    = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_frame_byte    = m_frame_byte_reg;
    assign m_byte_position = m_byte_position_reg;
    assign m_last          = m_last_reg;

endmodule

// ===== rtl/flfsr_ctrl.sv =====
// Controller: collection, checksum scan, output sequencing and resync search and shift.
module flfsr_ctrl #(
    parameter int STORE_DEPTH = 16,
    localparam int IDX_W = $clog2(STORE_DEPTH),
    localparam int LEN_W = $clog2(STORE_DEPTH + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [LEN_W-1:0]      eff_len,
    input  flfsr_pkg::dp_status_t status,
    output flfsr_pkg::dp_cmd_t    cmd,
    output logic [IDX_W-1:0]      wr_idx,
    output logic [IDX_W-1:0]      rd_idx,
    output logic [IDX_W-1:0]      out_pos
);

    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] ST_IDLE = 3'd0;
    localparam logic [STATE_W-1:0] ST_COLL = 3'd1;
    localparam logic [STATE_W-1:0] ST_SUM  = 3'd2;
    localparam logic [STATE_W-1:0] ST_OUT  = 3'd3;
    localparam logic [STATE_W-1:0] ST_SRCH = 3'd4;
    localparam logic [STATE_W-1:0] ST_SHFT = 3'd5;

    logic [STATE_W-1:0] state_reg, state_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [IDX_W-1:0]   sh_reg, sh_next;
    logic [LEN_W-1:0]   fill_reg, fill_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   len_m1;
    logic [LEN_W-1:0]   pos;
    logic               k_at_end;
    logic               accept;

    assign s_ready  = (state_reg == ST_IDLE) || (state_reg == ST_COLL);
    assign accept   = s_valid && s_ready;
    assign len_m1   = len_reg - LEN_W'(1);
    assign k_at_end = (LEN_W'(k_reg) == len_m1);
    assign pos      = (fill_reg < eff_len) ? fill_reg : eff_len - LEN_W'(1);

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        sh_next    = sh_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        cmd        = '0;
        wr_idx     = '0;
        rd_idx     = k_reg;
        out_pos    = k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && status.rx_is_start) begin
                    cmd.wr_en  = 1'b1;
                    fill_next  = LEN_W'(1);
                    state_next = ST_COLL;
                end
            end
            ST_COLL: begin
                if (accept) begin
                    cmd.wr_en = 1'b1;
                    wr_idx    = IDX_W'(pos);
                    fill_next = pos + LEN_W'(1);
                    if (pos + LEN_W'(1) >= eff_len) begin
                        cmd.sum_clr = 1'b1;
                        cmd.snap    = 1'b1;
                        len_next    = eff_len;
                        k_next      = IDX_W'(1);
                        state_next  = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                if (!k_at_end) begin
                    cmd.sum_add = 1'b1;
                    k_next      = k_reg + IDX_W'(1);
                end else if (status.sum_ok) begin
                    k_next     = '0;
                    state_next = ST_OUT;
                end else begin
                    k_next     = IDX_W'(1);
                    state_next = ST_SRCH;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = k_at_end;
                    if (k_at_end) begin
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end else begin
                        k_next = k_reg + IDX_W'(1);
                    end
                end
            end
            ST_SRCH: begin
                if (status.rd_is_start) begin
                    sh_next    = k_reg;
                    fill_next  = len_reg - LEN_W'(k_reg);
                    state_next = ST_SHFT;
                end else if (k_at_end) begin
                    fill_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_SHFT: begin
                cmd.shift = 1'b1;
                sh_next   = sh_reg - IDX_W'(1);
                if (sh_reg == IDX_W'(1)) begin
                    state_next = ST_COLL;
                end
            end
            default: begin
                state_next = ST_IDLE;
                fill_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            k_reg     <= '0;
            sh_reg    <= '0;
            len_reg   <= LEN_W'(flfsr_pkg::MIN_LEN);
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            k_reg     <= k_next;
            sh_reg    <= sh_next;
            len_reg   <= len_next;
        end
    end

endmodule

// ===== rtl/fixed_length_frame_sync_receiver.sv =====
// Top level of the start-byte fixed-length frame sync receiver with additive checksum.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_rx_byte
//   m_        out        m_valid/m_ready    m_frame_byte, m_byte_position, m_last
//   cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// One byte per cycle is taken while idle or collecting. The byte that completes a frame of
// length L starts the checksum scan over the frame store, then either output of the L bytes,
// or a start-byte search over stored positions 1 to L-1 and a shift of one place per cycle.
// s_ready is low from the completing byte until the frame is out or resync ends; a stalled
// m_ready holds the output register and the sequencer. Synchronous active-low reset clears
// control state and restores the register defaults; no clearing pass is needed.
module fixed_length_frame_sync_receiver #(
    parameter int MAX_FRAME = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [flfsr_pkg::BYTE_W-1:0]         s_rx_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [flfsr_pkg::BYTE_W-1:0]         m_frame_byte,
    output logic [flfsr_pkg::POS_W-1:0]          m_byte_position,
    output logic                                 m_last,
    input  logic                                 cfg_wr_en,
    input  logic [flfsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [flfsr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int STORE_DEPTH = (MAX_FRAME < flfsr_pkg::LEN_CAP) ? MAX_FRAME
                                                                   : flfsr_pkg::LEN_CAP;
    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int LEN_W = $clog2(STORE_DEPTH + 1);

    logic [flfsr_pkg::BYTE_W-1:0] start_byte;
    logic                         checksum_enable;
    logic [LEN_W-1:0]             eff_len;
    flfsr_pkg::dp_cmd_t           cmd;
    flfsr_pkg::dp_status_t        status;
    logic [IDX_W-1:0]             wr_idx;
    logic [IDX_W-1:0]             rd_idx;
    logic [IDX_W-1:0]             out_pos;

    flfsr_cfg #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_cfg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .start_byte      (start_byte),
        .checksum_enable (checksum_enable),
        .eff_len         (eff_len)
    );

    flfsr_ctrl #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .eff_len (eff_len),
        .status  (status),
        .cmd     (cmd),
        .wr_idx  (wr_idx),
        .rd_idx  (rd_idx),
        .out_pos (out_pos)
    );

    flfsr_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .wr_idx          (wr_idx),
        .rd_idx          (rd_idx),
        .out_pos         (out_pos),
        .rx_byte         (s_rx_byte),
        .start_byte      (start_byte),
        .checksum_enable (checksum_enable),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_byte    (m_frame_byte),
        .m_byte_position (m_byte_position),
        .m_last          (m_last)
    );

endmodule
